### sv/hpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
`default_nettype none

package hpq_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned ST_W  = 2;

  // operation codes (input tuser)
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

  // status codes (output tuser)
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PAY_W-1:0] payload;
    logic [KEY_W-1:0] key;
  } res_t;

endpackage

`default_nettype wire

### sv/hpq_mem.sv
// Entry store: one write port, one registered read port.
`default_nettype none

module hpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire hpq_pkg::entry_t  wdata,
  input  wire logic [AW-1:0]    raddr,
  output hpq_pkg::entry_t       rdata
);

  hpq_pkg::entry_t mem_r [DEPTH];
  hpq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/hpq_ctrl.sv
// Heap sequencer: append, bottom-up build and extract with hole-based sift-down.
`default_nettype none

module hpq_ctrl #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_vld,
  output logic                                     in_rdy,
  input  wire logic [hpq_pkg::OP_W-1:0]            in_op,
  input  wire hpq_pkg::entry_t                     in_ent,
  output logic                                     res_vld,
  input  wire logic                                res_rdy,
  output hpq_pkg::res_t                            res,
  output logic                                     mem_we,
  output logic [$clog2(CAPACITY)-1:0]              mem_waddr,
  output hpq_pkg::entry_t                          mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]              mem_raddr,
  input  wire hpq_pkg::entry_t                     mem_rdata
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CHW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXT_ROOT, S_EXT_LAST, S_BLD_RD, S_BLD_CAP,
    S_SIFT_L, S_SIFT_R, S_SIFT_C, S_FIN
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               lim_r;
  logic [AW-1:0]               node_r;
  logic [AW-1:0]               bld_i_r;
  logic [hpq_pkg::OP_W-1:0]    op_r;
  hpq_pkg::entry_t             cur_r;
  hpq_pkg::entry_t             lft_ent_r;
  hpq_pkg::res_t               res_r;

  logic [CHW-1:0]              lft;
  logic [CHW-1:0]              rgt;
  logic [CHW-1:0]              lim_x;
  logic                        lft_out;
  logic                        rgt_ok;
  logic                        go_r;
  logic                        go_l;
  logic                        stay;
  logic                        more;
  logic [hpq_pkg::KEY_W-1:0]   win_key;
  logic [CW-1:0]               last_c;
  logic [CW-1:0]               half_m1;
  logic                        has_room;
  logic [hpq_pkg::ST_W-1:0]    in_status;

  assign lft      = CHW'({node_r, 1'b1});
  assign rgt      = lft + CHW'(1);
  assign lim_x    = CHW'(lim_r);
  assign lft_out  = (lft >= lim_x);
  assign rgt_ok   = (rgt < lim_x);
  // right child is tried first, so it wins on equal keys
  assign go_r     = rgt_ok && (mem_rdata.key > cur_r.key);
  assign win_key  = go_r ? mem_rdata.key : cur_r.key;
  assign go_l     = (lft_ent_r.key > win_key);
  assign stay     = !go_r && !go_l;
  assign more     = (op_r == hpq_pkg::OP_BUILD) && (bld_i_r != '0);
  assign last_c   = cnt_r - CW'(1);
  assign half_m1  = (cnt_r >> 1) - CW'(1);
  assign has_room = (cnt_r < CW'(CAPACITY));

  // status known at acceptance: full append or empty extract
  assign in_status = ((in_op == hpq_pkg::OP_APPEND) && !has_room) ? hpq_pkg::ST_FULL :
                     ((in_op == hpq_pkg::OP_EXTRACT) && (cnt_r == '0)) ? hpq_pkg::ST_EMPTY :
                     hpq_pkg::ST_OK;

  assign in_rdy  = (state_r == S_IDLE);
  assign res_vld = (state_r == S_FIN);
  assign res     = res_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_r;
    mem_wdata = cur_r;
    mem_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (in_vld && (in_op == hpq_pkg::OP_APPEND) && has_room) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
          mem_wdata = in_ent;
        end
      end
      S_EXT_ROOT: mem_raddr = last_c[AW-1:0];
      S_BLD_RD:   mem_raddr = bld_i_r;
      S_SIFT_L: begin
        if (lft_out) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = lft[AW-1:0];
        end
      end
      S_SIFT_R: mem_raddr = rgt[AW-1:0];
      S_SIFT_C: begin
        mem_we = 1'b1;
        if (go_l) begin
          mem_wdata = lft_ent_r;
        end else if (go_r) begin
          mem_wdata = mem_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_vld) begin
            op_r  <= in_op;
            res_r <= '{status: in_status, payload: '0, key: '0};
            case (in_op)
              hpq_pkg::OP_APPEND: begin
                if (has_room) begin
                  cnt_r <= cnt_r + CW'(1);
                end
                state_r <= S_FIN;
              end
              hpq_pkg::OP_BUILD: begin
                if (cnt_r >= CW'(2)) begin
                  bld_i_r <= half_m1[AW-1:0];
                  lim_r   <= cnt_r;
                  state_r <= S_BLD_RD;
                end else begin
                  state_r <= S_FIN;
                end
              end
              hpq_pkg::OP_EXTRACT: begin
                if (cnt_r == '0) begin
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_EXT_ROOT;
                end
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_EXT_ROOT: begin
          res_r   <= '{status: hpq_pkg::ST_OK, payload: mem_rdata.payload,
                       key: mem_rdata.key};
          cnt_r   <= last_c;
          lim_r   <= last_c;
          state_r <= S_EXT_LAST;
        end
        S_EXT_LAST: begin
          cur_r   <= mem_rdata;
          node_r  <= '0;
          state_r <= S_SIFT_L;
        end
        S_BLD_RD: state_r <= S_BLD_CAP;
        S_BLD_CAP: begin
          cur_r   <= mem_rdata;
          node_r  <= bld_i_r;
          state_r <= S_SIFT_L;
        end
        S_SIFT_L: begin
          if (lft_out) begin
            if (more) begin
              bld_i_r <= bld_i_r - AW'(1);
              state_r <= S_BLD_RD;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_SIFT_R;
          end
        end
        S_SIFT_R: begin
          lft_ent_r <= mem_rdata;
          state_r   <= S_SIFT_C;
        end
        S_SIFT_C: begin
          if (stay) begin
            if (more) begin
              bld_i_r <= bld_i_r - AW'(1);
              state_r <= S_BLD_RD;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            node_r  <= go_l ? lft[AW-1:0] : rgt[AW-1:0];
            state_r <= S_SIFT_L;
          end
        end
        S_FIN: begin
          if (res_rdy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
//
//  channel | dir | tdata (low bit up)               | tuser
//  --------+-----+----------------------------------+-----------------
//  in_     | in  | key[30:0], payload[62:31], pad 0 | opcode[1:0]
//  out_    | out | key[30:0], payload[62:31], pad 0 | status[1:0]
//
// One operation at a time; a new one is taken once the last has finished.
// Append, error cases, short build and unused opcode go from acceptance to the result.
// Build: per parent, last to root, a read, a capture and a sift-down; then the result.
// Extract: root read, last-entry read, sift-down from the root, then the result.
// The steps are set by the single read port of the entry store: each sift
// level reads the left child, then the right child, then compares and writes.
// Reset clears the entry count, not the store; the store needs no clearing pass.
// A result waits in the output register while the next operation runs; the
// result cycle repeats while that register is still full and not drained.
`default_nettype none

module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key[30:0], payload[62:31], zero[63]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // key[30:0], payload[62:31], zero[63]
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam int unsigned AW = $clog2(CAPACITY);

  hpq_pkg::entry_t in_ent;
  hpq_pkg::res_t   res;
  logic            res_vld;
  logic            res_rdy;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  hpq_pkg::entry_t mem_wdata;
  hpq_pkg::entry_t mem_rdata;

  logic            out_vld_r;
  hpq_pkg::res_t   out_res_r;

  // unpack input beat
  assign in_ent.key     = in_tdata[hpq_pkg::KEY_W-1:0];
  assign in_ent.payload = in_tdata[hpq_pkg::KEY_W+hpq_pkg::PAY_W-1:hpq_pkg::KEY_W];

  hpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_tvalid),
    .in_rdy    (in_tready),
    .in_op     (in_tuser),
    .in_ent    (in_ent),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  hpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_rdy = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_vld_r <= 1'b1;
      out_res_r <= res;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.payload, out_res_r.key};
  assign out_tuser  = out_res_r.status;

endmodule

`default_nettype wire

### sv/hpq_chk.sv
// Port-level checks for the max-heap priority queue, bound to the top level.
`default_nettype none

module hpq_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // every accepted operation leaves the idle state, so ready drops after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");

  // full and empty results carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != hpq_pkg::ST_OK) |-> (out_tdata == '0))
    else $error("error result carries data");

endmodule

bind max_heap_priority_queue hpq_chk u_hpq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
